>>> rtl/bpa_pkg.sv
// Shared types and constants for the two-class block pool allocator.
`default_nettype none
package bpa_pkg;

    localparam int REQ_BYTES_W = 16;
    localparam int CLASS_MAX_W = 12;
    localparam int INDEX_W     = 4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic POOL_SMALL  = 1'b0;
    localparam logic POOL_MEDIUM = 1'b1;

    localparam logic [0:0] CFG_SMALL_MAX  = 1'b0;
    localparam logic [0:0] CFG_MEDIUM_MAX = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_RELEASED  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_IDLE_FREE = 3'd4
    } status_t;

    typedef struct packed {
        logic                   opcode;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic                   free_pool;
        logic [INDEX_W-1:0]     free_index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               grant_pool;
        logic [INDEX_W-1:0] grant_index;
    } result_t;

    typedef struct packed {
        logic [CLASS_MAX_W-1:0] small_max;
        logic [CLASS_MAX_W-1:0] medium_max;
    } cfg_t;

endpackage
`default_nettype wire

>>> rtl/bpa_pool_state.sv
// Free lists, in-use flags and the combinational allocate/free decision.
`default_nettype none
module bpa_pool_state #(
    parameter int BLOCKS_PER_POOL = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            exec,
    input  wire bpa_pkg::req_t   req,
    input  wire bpa_pkg::cfg_t   cfg,
    output bpa_pkg::result_t     res
);
    import bpa_pkg::*;

    localparam int LW = $clog2(BLOCKS_PER_POOL + 1);
    localparam int IW = $clog2(BLOCKS_PER_POOL);
    localparam logic [LW-1:0] END_MARK = LW'(BLOCKS_PER_POOL);

    logic [LW-1:0] head_reg    [2];
    logic [LW-1:0] head_next   [2];
    logic [LW-1:0] link_reg    [2][BLOCKS_PER_POOL];
    logic [LW-1:0] link_next   [2][BLOCKS_PER_POOL];
    logic          in_use_reg  [2][BLOCKS_PER_POOL];
    logic          in_use_next [2][BLOCKS_PER_POOL];

    logic          sel_pool;
    logic          too_large;
    logic [LW-1:0] head_sel;
    logic [IW-1:0] head_idx;
    logic [IW-1:0] fidx;
    logic          fidx_ok;

    assign head_sel = head_reg[sel_pool];
    assign head_idx = head_sel[IW-1:0];
    assign fidx     = IW'(req.free_index);
    assign fidx_ok  = int'(req.free_index) < BLOCKS_PER_POOL;

    always_comb begin
        sel_pool  = POOL_SMALL;
        too_large = 1'b0;
        priority if (req.request_bytes <= REQ_BYTES_W'(cfg.small_max)) begin
            sel_pool = POOL_SMALL;
        end else if (req.request_bytes <= REQ_BYTES_W'(cfg.medium_max)) begin
            sel_pool = POOL_MEDIUM;
        end else begin
            too_large = 1'b1;
        end
    end

    always_comb begin
        head_next   = head_reg;
        link_next   = link_reg;
        in_use_next = in_use_reg;
        res.status      = ST_IDLE_FREE;
        res.grant_pool  = req.free_pool;
        res.grant_index = req.free_index;
        if (req.opcode == OP_ALLOC) begin
            if (too_large) begin
                res.status      = ST_TOO_LARGE;
                res.grant_pool  = 1'b0;
                res.grant_index = '0;
            end else if (head_sel >= END_MARK) begin
                res.status      = ST_EMPTY;
                res.grant_pool  = sel_pool;
                res.grant_index = '0;
            end else begin
                res.status      = ST_GRANTED;
                res.grant_pool  = sel_pool;
                res.grant_index = INDEX_W'(head_sel);
                if (exec) begin
                    head_next[sel_pool]             = link_reg[sel_pool][head_idx];
                    in_use_next[sel_pool][head_idx] = 1'b1;
                end
            end
        end else if (fidx_ok && in_use_reg[req.free_pool][fidx]) begin
            res.status = ST_RELEASED;
            if (exec) begin
                in_use_next[req.free_pool][fidx] = 1'b0;
                link_next[req.free_pool][fidx]   = head_reg[req.free_pool];
                head_next[req.free_pool]         = LW'(fidx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < 2; p++) begin
                head_reg[p] <= '0;
                for (int i = 0; i < BLOCKS_PER_POOL; i++) begin
                    link_reg[p][i]   <= LW'(i + 1);
                    in_use_reg[p][i] <= 1'b0;
                end
            end
        end else begin
            head_reg   <= head_next;
            link_reg   <= link_next;
            in_use_reg <= in_use_next;
        end
    end

    // a grant never hands out a block that is already taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec && res.status == ST_GRANTED |-> !in_use_reg[res.grant_pool][head_idx])
        else $error("granted block already in use");

    // a released block becomes the head of its pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec && res.status == ST_RELEASED
        |=> head_reg[$past(req.free_pool)] == LW'($past(fidx)))
        else $error("released block not at list head");

    // heads never point past the end mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[0] <= END_MARK && head_reg[1] <= END_MARK)
        else $error("free list head out of range");

    // a released block is marked free afterwards
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec && res.status == ST_RELEASED |=> !in_use_reg[$past(req.free_pool)][$past(fidx)])
        else $error("released block still marked in use");

endmodule
`default_nettype wire

>>> rtl/two_class_block_pool_allocator_core.sv
// Top level: request/result stream registers, class limit registers, pool state.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser is the opcode (0 allocate, 1 free),
//   s_tdata carries the byte count and, for a free, the pool and block index.
//   Every request yields exactly one result on the m_ stream: m_tuser is the
//   status code, m_tdata the pool and block index that was granted or released.
//   A request taken into the input register is processed combinationally out of
//   it, and its result is registered in the output register.
//   Throughput is one request per cycle while the receiver does not stall; each
//   granted or released request is a single pop or push on the per-pool link
//   table and head, done combinationally between the input and output registers.
//   When the receiver stalls, the result is held in the output register and
//   one more request waits in the input register; s_tready then drops.
//   Reset chains every pool as 0,1,2,... with all blocks free and loads the
//   class limits with 64 and 128 bytes. The user must write the limits via the
//   cfg_ port only while no request is in flight; the block does not enforce it.
`default_nettype none
module two_class_block_pool_allocator_core #(
    parameter int BLOCKS_PER_POOL = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // request_bytes[15:0], free_pool[16], free_index[20:17]
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // grant_pool[0], grant_index[4:1]
    output logic [2:0]       m_tuser,   // status
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata
);
    import bpa_pkg::*;

    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    req_t    req_reg;
    result_t res_reg;
    result_t res;
    cfg_t    cfg_reg;
    logic    s_accept;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg.opcode        <= s_tuser;
            req_reg.request_bytes <= s_tdata[15:0];
            req_reg.free_pool     <= s_tdata[16];
            req_reg.free_index    <= s_tdata[20:17];
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.small_max  <= 12'd64;
            cfg_reg.medium_max <= 12'd128;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SMALL_MAX:  cfg_reg.small_max  <= cfg_wdata;
                CFG_MEDIUM_MAX: cfg_reg.medium_max <= cfg_wdata;
            endcase
        end
    end

    bpa_pool_state #(
        .BLOCKS_PER_POOL(BLOCKS_PER_POOL)
    ) u_pool_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (advance),
        .req     (req_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'b000, res_reg.grant_index, res_reg.grant_pool};

endmodule
`default_nettype wire
